@@ design/assert_macros.svh @@
// assertion helpers shared by the design files
// both expect clk_i and rst_ni in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DHSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dhss: check failed");
`define DHSS_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("dhss: forbidden condition seen");
`else
`define DHSS_ASSERT(lbl, prop)
`define DHSS_NEVER(lbl, expr)
`endif
`endif

@@ design/dhss_pkg.sv @@
`default_nettype none
package dhss_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned SlotW    = $clog2(MaxSlots);
  localparam int unsigned MaxLog2  = SlotW;
  localparam int unsigned InitLog2 = 3;
  localparam int unsigned MaxChars = 8;
  localparam int unsigned AddrW    = SlotW + 1;
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned LogW     = $clog2(MaxLog2 + 1);
  localparam int unsigned HashW    = 32;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned LenW     = 4;
  localparam int unsigned Depth    = 2 * MaxSlots;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_GONE  = 2'd2
  } tag_e;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef struct packed {
    tag_e              tag;
    logic [LenW-1:0]   len;
    logic [HashW-1:0]  hash;
    logic [KeyW-1:0]   key;
  } entry_t;

  typedef enum logic [2:0] {
    ADDR_ALL,
    ADDR_NEW_SWEEP,
    ADDR_OLD_SWEEP,
    ADDR_PROBE,
    ADDR_NEW_PROBE,
    ADDR_HIT,
    ADDR_DST
  } addr_sel_e;

  typedef enum logic [1:0] {
    WR_EMPTY,
    WR_GONE,
    WR_NEW,
    WR_MOVE
  } wr_sel_e;

  typedef struct packed {
    logic      latch;
    logic      hash_step;
    logic      seek_init;
    logic      move_init;
    logic      probe_next;
    logic      note_gone;
    logic      note_hit;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      rd_en;
    logic      wr_en;
    addr_sel_e addr_sel;
    wr_sel_e   wr_sel;
    logic      live_inc;
    logic      live_dec;
    logic      grow_done;
    logic      out_load;
    logic      out_ok;
    logic      out_ovf;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  hash_done;
    logic  grow_need;
    logic  at_max;
    tag_e  tag;
    logic  key_match;
    logic  probe_last;
    logic  gone_seen;
    logic  all_last;
    logic  new_last;
    logic  old_last;
  } stat_t;

endpackage
`default_nettype wire

@@ design/dhss_dp.sv @@
`default_nettype none
module dhss_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [dhss_pkg::KeyW-1:0]     key_chars_i,
  input  wire logic [dhss_pkg::LenW-1:0]     key_length_i,
  input  wire dhss_pkg::cmd_t                cmd_i,
  output dhss_pkg::stat_t                    stat_o,
  output logic                               ok_o,
  output logic                               overflow_o,
  output logic [dhss_pkg::CountW-1:0]        key_count_o
);

  // request registers
  dhss_pkg::kind_e                 kind_q;
  logic [dhss_pkg::KeyW-1:0]       key_q;
  logic [dhss_pkg::LenW-1:0]       len_q;
  logic [dhss_pkg::HashW-1:0]      hash_q;
  logic [dhss_pkg::LenW-1:0]       cnt_q;

  // probe walk
  logic [dhss_pkg::SlotW-1:0]      at_q, step_q, hit_q, gone_idx_q;
  logic [dhss_pkg::CountW-1:0]     probe_q;
  logic                            gone_seen_q;
  dhss_pkg::entry_t                mov_q;

  // table state
  logic                            bank_q;
  logic [dhss_pkg::LogW-1:0]       size_log2_q;
  logic [dhss_pkg::CountW-1:0]     live_q;
  logic [dhss_pkg::AddrW-1:0]      ptr_q;

  dhss_pkg::entry_t                mem_q [dhss_pkg::Depth];
  dhss_pkg::entry_t                rd_q;

  logic                            ok_q, ovf_q;
  logic [dhss_pkg::CountW-1:0]     count_q;

  logic [dhss_pkg::LenW-1:0]       len_c;
  logic [dhss_pkg::KeyW-1:0]       key_m;
  logic [7:0]                      byte_cur;
  logic [dhss_pkg::CountW-1:0]     size, size_m1, nsize_m1;
  logic [dhss_pkg::SlotW-1:0]      probe_idx, new_idx;
  logic [dhss_pkg::AddrW-1:0]      addr;
  dhss_pkg::entry_t                wdata;
  logic [dhss_pkg::CountW+1:0]     live4, thresh;

  // cap length and clear the bytes past the key
  always_comb begin
    len_c = (key_length_i > dhss_pkg::LenW'(dhss_pkg::MaxChars)) ?
            dhss_pkg::LenW'(dhss_pkg::MaxChars) : key_length_i;
    for (int b = 0; b < 8; b++) begin
      key_m[(dhss_pkg::KeyW-8) - 8*b +: 8] =
        (dhss_pkg::LenW'(b) < len_c) ? key_chars_i[(dhss_pkg::KeyW-8) - 8*b +: 8] : 8'h00;
    end
  end

  assign byte_cur  = key_q[(dhss_pkg::KeyW-8) - 8*cnt_q[2:0] +: 8];
  assign size      = dhss_pkg::CountW'(1) << size_log2_q;
  assign size_m1   = size - dhss_pkg::CountW'(1);
  assign nsize_m1  = (size << 1) - dhss_pkg::CountW'(1);
  assign probe_idx = at_q & size_m1[dhss_pkg::SlotW-1:0];
  assign new_idx   = at_q & nsize_m1[dhss_pkg::SlotW-1:0];
  assign live4     = {live_q, 2'b00};
  assign thresh    = (dhss_pkg::CountW+2)'(3) << size_log2_q;

  always_comb begin
    case (cmd_i.addr_sel)
      dhss_pkg::ADDR_ALL:       addr = ptr_q;
      dhss_pkg::ADDR_NEW_SWEEP: addr = {~bank_q, ptr_q[dhss_pkg::SlotW-1:0]};
      dhss_pkg::ADDR_OLD_SWEEP: addr = {bank_q, ptr_q[dhss_pkg::SlotW-1:0]};
      dhss_pkg::ADDR_PROBE:     addr = {bank_q, probe_idx};
      dhss_pkg::ADDR_NEW_PROBE: addr = {~bank_q, new_idx};
      dhss_pkg::ADDR_HIT:       addr = {bank_q, hit_q};
      dhss_pkg::ADDR_DST:       addr = {bank_q, gone_seen_q ? gone_idx_q : hit_q};
      default:                  addr = ptr_q;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      dhss_pkg::WR_EMPTY: wdata = '{tag: dhss_pkg::TAG_EMPTY, len: '0, hash: '0, key: '0};
      dhss_pkg::WR_GONE:  wdata = '{tag: dhss_pkg::TAG_GONE, len: len_q, hash: hash_q,
                                    key: key_q};
      dhss_pkg::WR_NEW:   wdata = '{tag: dhss_pkg::TAG_LIVE, len: len_q, hash: hash_q,
                                    key: key_q};
      dhss_pkg::WR_MOVE:  wdata = '{tag: dhss_pkg::TAG_LIVE, len: mov_q.len, hash: mov_q.hash,
                                    key: mov_q.key};
      default:            wdata = '{tag: dhss_pkg::TAG_EMPTY, len: '0, hash: '0, key: '0};
    endcase
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= dhss_pkg::kind_e'(kind_i);
      key_q  <= key_m;
      len_q  <= len_c;
      hash_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.hash_step) begin
      hash_q <= (hash_q << 4) + hash_q + dhss_pkg::HashW'(byte_cur);
      cnt_q  <= cnt_q + dhss_pkg::LenW'(1);
    end
    if (cmd_i.seek_init) begin
      at_q        <= hash_q[dhss_pkg::SlotW-1:0];
      step_q      <= {hash_q[dhss_pkg::SlotW-2:0], 1'b1};
      probe_q     <= '0;
      gone_seen_q <= 1'b0;
    end else if (cmd_i.move_init) begin
      mov_q  <= rd_q;
      at_q   <= rd_q.hash[dhss_pkg::SlotW-1:0];
      step_q <= {rd_q.hash[dhss_pkg::SlotW-2:0], 1'b1};
    end else if (cmd_i.probe_next) begin
      at_q    <= at_q + step_q;
      probe_q <= probe_q + dhss_pkg::CountW'(1);
    end
    if (cmd_i.note_gone && !gone_seen_q) begin
      gone_seen_q <= 1'b1;
      gone_idx_q  <= probe_idx;
    end
    if (cmd_i.note_hit) begin
      hit_q <= probe_idx;
    end
    if (cmd_i.out_load) begin
      ok_q    <= cmd_i.out_ok;
      ovf_q   <= cmd_i.out_ovf;
      count_q <= live_q;
    end
  end

  // table control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= 1'b0;
      size_log2_q <= dhss_pkg::LogW'(dhss_pkg::InitLog2);
      live_q      <= '0;
      ptr_q       <= '0;
    end else begin
      if (cmd_i.grow_done) begin
        bank_q      <= ~bank_q;
        size_log2_q <= size_log2_q + dhss_pkg::LogW'(1);
      end
      if (cmd_i.live_inc) begin
        live_q <= live_q + dhss_pkg::CountW'(1);
      end else if (cmd_i.live_dec) begin
        live_q <= live_q - dhss_pkg::CountW'(1);
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + dhss_pkg::AddrW'(1);
      end
    end
  end

  assign stat_o.kind       = kind_q;
  assign stat_o.hash_done  = (cnt_q == len_q);
  assign stat_o.grow_need  = (live4 >= thresh);
  assign stat_o.at_max     = (size_log2_q == dhss_pkg::LogW'(dhss_pkg::MaxLog2));
  assign stat_o.tag        = rd_q.tag;
  assign stat_o.key_match  = (rd_q.key == key_q) && (rd_q.len == len_q);
  assign stat_o.probe_last = (probe_q == size_m1);
  assign stat_o.gone_seen  = gone_seen_q;
  assign stat_o.all_last   = (ptr_q == {dhss_pkg::AddrW{1'b1}});
  assign stat_o.new_last   = (ptr_q == nsize_m1);
  assign stat_o.old_last   = (ptr_q == size_m1);

  assign ok_o        = ok_q;
  assign overflow_o  = ovf_q;
  assign key_count_o = count_q;

  `include "assert_macros.svh"

  `DHSS_ASSERT(a_live_bounded, live_q <= dhss_pkg::CountW'(dhss_pkg::MaxSlots))
  `DHSS_NEVER(a_grow_past_max, cmd_i.grow_done && stat_o.at_max)
  `DHSS_ASSERT(a_load_count, cmd_i.out_load |=> (key_count_o == $past(live_q)))

endmodule
`default_nettype wire

@@ design/dhss_ctrl.sv @@
`default_nettype none
module dhss_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire dhss_pkg::stat_t stat_i,
  output dhss_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_PRD, S_PCHK, S_ACT, S_DONE,
    S_GCLR, S_GRD, S_GCHK, S_GPRD, S_GPCHK, S_GFIN
  } state_e;

  state_e state_q, state_d;
  logic   found_q, found_d, empty_q, empty_d;
  logic   res_ok_q, res_ok_d, res_ovf_q, res_ovf_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    empty_d     = empty_q;
    res_ok_d    = res_ok_q;
    res_ovf_d   = res_ovf_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.addr_sel = dhss_pkg::ADDR_ALL;
    cmd_o.wr_sel   = dhss_pkg::WR_EMPTY;

    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.all_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (!stat_i.hash_done) begin
          cmd_o.hash_step = 1'b1;
        end else begin
          res_ok_d  = 1'b0;
          res_ovf_d = 1'b0;
          case (stat_i.kind)
            dhss_pkg::KIND_ADD: begin
              if (stat_i.grow_need && stat_i.at_max) begin
                res_ovf_d = 1'b1;
                state_d = S_DONE;
              end else if (stat_i.grow_need) begin
                cmd_o.ptr_clr = 1'b1;
                state_d = S_GCLR;
              end else begin
                cmd_o.seek_init = 1'b1;
                state_d = S_PRD;
              end
            end
            dhss_pkg::KIND_DEL, dhss_pkg::KIND_QUERY: begin
              cmd_o.seek_init = 1'b1;
              state_d = S_PRD;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = dhss_pkg::ADDR_PROBE;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        found_d = 1'b0;
        empty_d = 1'b0;
        if (stat_i.tag == dhss_pkg::TAG_EMPTY) begin
          cmd_o.note_hit = 1'b1;
          empty_d = 1'b1;
          state_d = S_ACT;
        end else if (stat_i.tag == dhss_pkg::TAG_LIVE && stat_i.key_match) begin
          cmd_o.note_hit = 1'b1;
          found_d = 1'b1;
          state_d = S_ACT;
        end else begin
          cmd_o.note_gone = (stat_i.tag == dhss_pkg::TAG_GONE);
          if (stat_i.probe_last) begin
            state_d = S_ACT;
          end else begin
            cmd_o.probe_next = 1'b1;
            state_d = S_PRD;
          end
        end
      end
      S_ACT: begin
        res_ok_d = 1'b0;
        case (stat_i.kind)
          dhss_pkg::KIND_ADD: begin
            if (!found_q && (empty_q || stat_i.gone_seen)) begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.addr_sel = dhss_pkg::ADDR_DST;
              cmd_o.wr_sel   = dhss_pkg::WR_NEW;
              cmd_o.live_inc = 1'b1;
              res_ok_d = 1'b1;
            end
          end
          dhss_pkg::KIND_DEL: begin
            if (found_q) begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.addr_sel = dhss_pkg::ADDR_HIT;
              cmd_o.wr_sel   = dhss_pkg::WR_GONE;
              cmd_o.live_dec = 1'b1;
              res_ok_d = 1'b1;
            end
          end
          dhss_pkg::KIND_QUERY: res_ok_d = found_q;
          default: res_ok_d = 1'b0;
        endcase
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_ok   = res_ok_q;
          cmd_o.out_ovf  = res_ovf_q;
          state_d = S_IDLE;
        end
      end
      S_GCLR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr_sel = dhss_pkg::ADDR_NEW_SWEEP;
        if (stat_i.new_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = S_GRD;
        end else begin
          cmd_o.ptr_inc = 1'b1;
        end
      end
      S_GRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = dhss_pkg::ADDR_OLD_SWEEP;
        state_d = S_GCHK;
      end
      S_GCHK: begin
        if (stat_i.tag == dhss_pkg::TAG_LIVE) begin
          cmd_o.move_init = 1'b1;
          state_d = S_GPRD;
        end else if (stat_i.old_last) begin
          state_d = S_GFIN;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = S_GRD;
        end
      end
      S_GPRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = dhss_pkg::ADDR_NEW_PROBE;
        state_d = S_GPCHK;
      end
      S_GPCHK: begin
        cmd_o.addr_sel = dhss_pkg::ADDR_NEW_PROBE;
        if (stat_i.tag == dhss_pkg::TAG_EMPTY) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = dhss_pkg::WR_MOVE;
          if (stat_i.old_last) begin
            state_d = S_GFIN;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d = S_GRD;
          end
        end else begin
          cmd_o.probe_next = 1'b1;
          state_d = S_GPRD;
        end
      end
      S_GFIN: begin
        cmd_o.grow_done = 1'b1;
        cmd_o.seek_init = 1'b1;
        state_d = S_PRD;
      end
      default: state_d = S_IDLE;
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      res_ok_q    <= 1'b0;
      res_ovf_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      found_q     <= found_d;
      empty_q     <= empty_d;
      res_ok_q    <= res_ok_d;
      res_ovf_q   <= res_ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `include "assert_macros.svh"

  `DHSS_ASSERT(a_accept_busy, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `DHSS_NEVER(a_live_both, cmd_o.live_inc && cmd_o.live_dec)
  `DHSS_NEVER(a_idle_quiet, in_ready_o && (cmd_o.wr_en || cmd_o.rd_en))

endmodule
`default_nettype wire

@@ design/double_hash_string_set.sv @@
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+-------------------------------------
// request | in        | in_valid_i/in_ready_o | kind_i, key_chars_i, key_length_i
// result  | out       | out_valid_o/out_ready_i | ok_o, overflow_o, key_count_o
//
// requests: one request at a time; each probe reads the single-port slot memory
//   (S_PRD) and then checks the slot that it read (S_PCHK)
// growth: clears the spare bank, then reads each old slot and re-probes each live entry into it
// reset: a clearing pass writes every slot of both banks empty, with
//   in_ready_o low
// stalls: one finished result waits in the output register; the next request is
//   taken meanwhile and only its own result waits for the slot to free
`default_nettype none
module double_hash_string_set (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [dhss_pkg::KeyW-1:0]     key_chars_i,
  input  wire logic [dhss_pkg::LenW-1:0]     key_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               ok_o,
  output logic                               overflow_o,
  output logic [dhss_pkg::CountW-1:0]        key_count_o
);

  // commands from the sequencer, status back from the table datapath
  dhss_pkg::cmd_t  cmd;
  dhss_pkg::stat_t stat;

  // sequencer: hashing, probe walk, growth and result handover
  dhss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: two-bank slot memory, hash, probe registers and counters
  dhss_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .key_chars_i  (key_chars_i),
    .key_length_i (key_length_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .ok_o         (ok_o),
    .overflow_o   (overflow_o),
    .key_count_o  (key_count_o)
  );

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dhss_pkg::*;

  // outcome of a walk along one probe chain
  typedef enum int {WALK_EMPTY, WALK_FOUND, WALK_DONE} walk_e;

  typedef struct packed {
    logic              ok;
    logic              overflow;
    logic [CountW-1:0] key_count;
  } reply_t;

  // scoreboard: keeps its own copy of both slot banks and predicts each reply
  class string_set_scoreboard;
    tag_e                 tag_mem [Depth];
    logic [KeyW-1:0]      key_mem [Depth];
    logic [HashW-1:0]     hash_mem[Depth];
    logic [LenW-1:0]      len_mem [Depth];
    int unsigned          bank;
    int unsigned          size_log2;
    int unsigned          live;
    reply_t               replies_due[$];
    int unsigned          errors;

    function new();
      foreach (tag_mem[i]) tag_mem[i] = TAG_EMPTY;
      bank = 0;
      size_log2 = InitLog2;
      live = 0;
      errors = 0;
    endfunction

    function logic [HashW-1:0] horner17(logic [KeyW-1:0] k, int unsigned n);
      logic [HashW-1:0] h;
      h = '0;
      for (int unsigned i = 0; i < n; i++) h = h * 17 + k[63 - 8 * i -: 8];
      return h;
    endfunction

    // walks the chain in the active bank; pos is the hit or the empty slot
    function walk_e walk(logic [HashW-1:0] h, logic [KeyW-1:0] k, logic [LenW-1:0] n,
                         output int unsigned pos, output int unsigned gone,
                         output bit has_gone);
      int unsigned      base;
      int unsigned      size;
      logic [HashW-1:0] at;
      int unsigned      idx;
      base = bank * MaxSlots;
      size = 1 << size_log2;
      at = h;
      has_gone = 0;
      gone = 0;
      pos = 0;
      for (int unsigned i = 0; i < size; i++) begin
        idx = base + (at & (size - 1));
        if (tag_mem[idx] == TAG_EMPTY) begin
          pos = idx;
          return WALK_EMPTY;
        end
        if (tag_mem[idx] == TAG_LIVE) begin
          if (key_mem[idx] == k && len_mem[idx] == n) begin
            pos = idx;
            return WALK_FOUND;
          end
        end else if (!has_gone) begin
          has_gone = 1;
          gone = idx;
        end
        at = at + 2 * h + 1;
      end
      return WALK_DONE;
    endfunction

    // doubles the table into the spare bank, old slots in ascending order
    function void double_size();
      int unsigned      size;
      int unsigned      nsize;
      int unsigned      obase;
      int unsigned      nbase;
      int unsigned      src;
      int unsigned      dst;
      logic [HashW-1:0] h;
      logic [HashW-1:0] at;
      size = 1 << size_log2;
      nsize = size * 2;
      obase = bank * MaxSlots;
      nbase = (bank ^ 1) * MaxSlots;
      for (int unsigned i = 0; i < nsize; i++) tag_mem[nbase + i] = TAG_EMPTY;
      for (int unsigned i = 0; i < size; i++) begin
        src = obase + i;
        if (tag_mem[src] == TAG_LIVE) begin
          h = hash_mem[src];
          at = h;
          for (int unsigned j = 0; j < nsize; j++) begin
            dst = nbase + (at & (nsize - 1));
            if (tag_mem[dst] == TAG_EMPTY) begin
              tag_mem[dst] = TAG_LIVE;
              key_mem[dst] = key_mem[src];
              hash_mem[dst] = h;
              len_mem[dst] = len_mem[src];
              break;
            end
            at = at + 2 * h + 1;
          end
        end
      end
      bank = bank ^ 1;
      size_log2++;
    endfunction

    function void note_request(logic [1:0] kind, logic [KeyW-1:0] k, logic [LenW-1:0] n);
      reply_t           r;
      logic [HashW-1:0] h;
      walk_e            w;
      int unsigned      pos;
      int unsigned      gone;
      int unsigned      dst;
      int unsigned      size;
      bit               has_gone;
      r = '0;
      if (n > MaxChars) n = LenW'(MaxChars);
      if (n == 0) k = '0;
      else if (n < 8) k = k & ({KeyW{1'b1}} << (64 - 8 * n));
      h = horner17(k, n);
      size = 1 << size_log2;
      case (kind_e'(kind))
        KIND_ADD: begin
          if (live * 4 >= size * 3) begin
            if (size * 2 > MaxSlots) r.overflow = 1;
            else double_size();
          end
          if (!r.overflow) begin
            w = walk(h, k, n, pos, gone, has_gone);
            if (w != WALK_FOUND && (w == WALK_EMPTY || has_gone)) begin
              dst = has_gone ? gone : pos;
              tag_mem[dst] = TAG_LIVE;
              key_mem[dst] = k;
              hash_mem[dst] = h;
              len_mem[dst] = n;
              live++;
              r.ok = 1;
            end
          end
        end
        KIND_DEL: begin
          w = walk(h, k, n, pos, gone, has_gone);
          if (w == WALK_FOUND) begin
            tag_mem[pos] = TAG_GONE;
            live--;
            r.ok = 1;
          end
        end
        KIND_QUERY: begin
          w = walk(h, k, n, pos, gone, has_gone);
          r.ok = (w == WALK_FOUND);
        end
        default: ;
      endcase
      r.key_count = live[CountW-1:0];
      replies_due.push_back(r);
    endfunction

    function void check_result(logic ok, logic ovf, logic [CountW-1:0] cnt);
      reply_t e;
      if (replies_due.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (ok !== e.ok) begin
        $error("ok: expected %0d, got %0d", e.ok, ok);
        errors++;
      end
      if (ovf !== e.overflow) begin
        $error("overflow: expected %0d, got %0d", e.overflow, ovf);
        errors++;
      end
      if (cnt !== e.key_count) begin
        $error("key_count: expected %0d, got %0d", e.key_count, cnt);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned PoolSize = 1200;
  localparam int unsigned Watchdog = 40000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        kind;
  logic [KeyW-1:0]   key_chars;
  logic [LenW-1:0]   key_length;
  logic              out_valid;
  logic              out_ready;
  logic              ok;
  logic              overflow;
  logic [CountW-1:0] key_count;

  string_set_scoreboard sb;
  logic [KeyW-1:0]      pool_key[PoolSize];
  logic [LenW-1:0]      pool_len[PoolSize];
  bit                   no_idle;      // quiet stretch: neither side idles
  int unsigned          stale_cycles;

  double_hash_string_set DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .key_chars_i (key_chars),
    .key_length_i(key_length),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .ok_o        (ok),
    .overflow_o  (overflow),
    .key_count_o (key_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // holds one request until it is taken, then maybe idles for a while
  task automatic send_request(logic [1:0] k, logic [KeyW-1:0] c, logic [LenW-1:0] n);
    in_valid   <= 1'b1;
    kind       <= k;
    key_chars  <= c;
    key_length <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(k, c, n);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // pool key with random junk in the bytes past its length
  function automatic logic [KeyW-1:0] with_junk(int unsigned i);
    logic [KeyW-1:0] junk;
    junk = {$urandom, $urandom};
    if (pool_len[i] >= 8) return pool_key[i];
    return pool_key[i] | (junk & ~({KeyW{1'b1}} << (64 - 8 * pool_len[i])));
  endfunction

  // result side: random back-pressure, check on each accepted reply
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(ok, overflow, key_count);
    out_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stale_cycles <= 0;
    else stale_cycles <= stale_cycles + 1;
    if (stale_cycles >= Watchdog) begin
      $display("double_hash_string_set test failed");
      $finish;
    end
  end

  initial begin
    int unsigned     next_new;
    int unsigned     pick;
    int unsigned     roll;
    logic [KeyW-1:0] word;
    sb = new();
    stale_cycles = 0;
    no_idle = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    kind = KIND_ADD;
    key_chars = '0;
    key_length = '0;
    out_ready = 1'b0;
    // lowercase pool, with a share of arbitrary bytes so every key bit toggles
    for (int unsigned i = 0; i < PoolSize; i++) begin
      pool_len[i] = LenW'($urandom_range(1, 8));
      word = '0;
      for (int unsigned b = 0; b < pool_len[i]; b++)
        word[63 - 8 * b -: 8] = (i % 10 == 0) ? 8'($urandom_range(255))
                                              : 8'($urandom_range(97, 122));
      pool_key[i] = word;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every kind, odd lengths, duplicates
    send_request(KIND_QUERY, '0, 4'd1);
    send_request(KIND_ADD, {KeyW{1'b1}}, 4'd8);
    send_request(KIND_ADD, {KeyW{1'b1}}, 4'd8);          // duplicate add
    send_request(KIND_QUERY, {KeyW{1'b1}}, 4'd15);       // long key cut to eight
    send_request(KIND_ADD, 64'h6100_0000_0000_0000, 4'd0); // empty key
    send_request(KIND_QUERY, {KeyW{1'b1}}, 4'd0);        // also the empty key
    send_request(KIND_ADD, 64'h61ff_ffff_ffff_ffff, 4'd1); // junk bytes ignored
    send_request(KIND_QUERY, 64'h6100_0000_0000_0000, 4'd1);
    send_request(KIND_QUERY, 64'h6100_0000_0000_0000, 4'd2); // same bytes, other length
    send_request(KIND_NONE, 64'h6100_0000_0000_0000, 4'd1);  // unused kind
    send_request(KIND_DEL, 64'h6100_0000_0000_0000, 4'd1);
    send_request(KIND_DEL, 64'h6100_0000_0000_0000, 4'd1);   // delete of a missing key
    send_request(KIND_ADD, 64'h6100_0000_0000_0000, 4'd1);   // reuses the tombstone
    send_request(KIND_ADD, 64'h0, 4'd8);
    send_request(KIND_ADD, 64'h7a7a_7a7a_7a00_0000, 4'd5);
    send_request(KIND_ADD, 64'h0102_0304_0506_0708, 4'd12);
    send_request(KIND_DEL, {KeyW{1'b1}}, 4'd8);
    send_request(KIND_QUERY, {KeyW{1'b1}}, 4'd8);
    send_request(KIND_ADD, 64'h5555_aaaa_5555_aaaa, 4'd7);

    // fill phase: mostly fresh adds at first, then mixed traffic, driving growth up to the overflow point
    next_new = 0;
    for (int unsigned n = 0; n < 1700; n++) begin
      no_idle = (n >= 400 && n < 650);
      roll = $urandom_range(99);
      if (n < 1050 && roll < 80 && next_new < PoolSize) begin
        pick = next_new++;
        send_request(KIND_ADD, with_junk(pick), pool_len[pick]);
      end else begin
        pick = $urandom_range(next_new > 0 ? next_new : PoolSize - 1);
        if (pick >= PoolSize) pick = PoolSize - 1;
        roll = $urandom_range(99);
        if (roll < 3)
          send_request(2'($urandom_range(3)), {$urandom, $urandom}, 4'($urandom_range(15)));
        else if (roll < 30)
          send_request(KIND_ADD, with_junk(pick), pool_len[pick]);
        else if (roll < 60)
          send_request(KIND_DEL, with_junk(pick), pool_len[pick]);
        else if (roll < 97)
          send_request(KIND_QUERY, with_junk(pick), pool_len[pick]);
        else
          send_request(KIND_NONE, with_junk(pick), pool_len[pick]);
      end
    end
    in_valid <= 1'b0;
    no_idle = 0;

    while (sb.replies_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("double_hash_string_set test passed");
    else $display("double_hash_string_set test failed");
    $finish;
  end
endmodule
`default_nettype wire
